// File: src/mdc22_pkg.sv
package mdc22_pkg;

  // input kind codes
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // stream widths
  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 24;

  // frame field sizes
  localparam int ADDR_W   = 5;
  localparam int HEADER_W = 2 * ADDR_W;
  localparam int DATA_W   = 16;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // classified command
  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_IDLE  = 2'd2
  } cmd_t;

  // one classified item
  typedef struct packed {
    cmd_t                cmd;
    logic                is_write;
    logic [HEADER_W-1:0] header;
    logic [DATA_W-1:0]   wdata;
    logic                sample;
  } item_t;

  // one result item
  typedef struct packed {
    logic              mdio_out;
    logic              mdio_drive_enable;
    logic              busy_res;
    logic              done_res;
    logic [DATA_W-1:0] read_data;
    logic              rejected;
  } res_t;

endpackage

// File: src/mdc22_front.sv
module mdc22_front
  import mdc22_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // phy_address[4:0], register_address[9:5], write_data[25:10], mdio_in[26]
  input  logic [IN_DATA_W-1:0] in_tdata,
  // kind[1:0]
  input  logic [IN_USER_W-1:0] in_tuser,
  output item_t                item_o,
  output logic                 item_valid_o,
  input  logic                 item_ready_i
);

  logic  front_valid_r;
  logic  front_valid_nxt;
  item_t item_r;
  item_t item_nxt;
  logic  accept;

  assign in_tready = !front_valid_r || item_ready_i;
  assign accept    = in_tvalid && in_tready;

  // classify the item and unpack its fields
  always_comb begin
    item_nxt.is_write = 1'b0;
    unique case (in_tuser) inside
      KIND_READ, KIND_WRITE: begin
        item_nxt.cmd      = CMD_START;
        item_nxt.is_write = (in_tuser == KIND_WRITE);
      end
      KIND_TICK: item_nxt.cmd = CMD_TICK;
      default:   item_nxt.cmd = CMD_IDLE;
    endcase
    item_nxt.header = {in_tdata[ADDR_W-1:0], in_tdata[HEADER_W-1:ADDR_W]};
    item_nxt.wdata  = in_tdata[HEADER_W+DATA_W-1:HEADER_W];
    item_nxt.sample = in_tdata[HEADER_W+DATA_W];
  end

  // holding stage toward the queue
  always_comb begin
    front_valid_nxt = front_valid_r;
    if (accept) begin
      front_valid_nxt = 1'b1;
    end else if (item_ready_i) begin
      front_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= front_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  assign item_o       = item_r;
  assign item_valid_o = front_valid_r;

endmodule

// File: src/mdc22_queue.sv
module mdc22_queue
  import mdc22_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  item_t push_item_i,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  output item_t pop_item_o,
  output logic  pop_valid_o,
  input  logic  pop_ready_i
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             push;
  logic             pop;

  assign push_ready_o = (count_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_r != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = entry_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item_i;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count missed a push");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == '0 |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers apart while empty");
`endif

endmodule

// File: src/mdc22_back.sv
module mdc22_back
  import mdc22_pkg::*;
#(
  parameter int PREAMBLE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  item_t                 item_i,
  input  logic                  item_valid_i,
  output logic                  item_ready_o,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // mdio_out[0], mdio_drive_enable[1], busy_res[2], read_data[18:3]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // done_res
  output logic                  out_tlast,
  // rejected
  output logic                  out_tuser
);

  localparam int POS_W = $clog2(PREAMBLE_BITS + 33);
  localparam logic [POS_W-1:0] P_START0  = POS_W'(PREAMBLE_BITS);
  localparam logic [POS_W-1:0] P_START1  = POS_W'(PREAMBLE_BITS + 1);
  localparam logic [POS_W-1:0] P_OP0     = POS_W'(PREAMBLE_BITS + 2);
  localparam logic [POS_W-1:0] P_OP1     = POS_W'(PREAMBLE_BITS + 3);
  localparam logic [POS_W-1:0] P_ADDR    = POS_W'(PREAMBLE_BITS + 4);
  localparam logic [POS_W-1:0] P_TA0     = POS_W'(PREAMBLE_BITS + 14);
  localparam logic [POS_W-1:0] P_TA1     = POS_W'(PREAMBLE_BITS + 15);
  localparam logic [POS_W-1:0] P_DATA    = POS_W'(PREAMBLE_BITS + 16);
  localparam logic [POS_W-1:0] P_LAST_RD = POS_W'(PREAMBLE_BITS + 31);
  localparam logic [POS_W-1:0] P_LAST_WR = POS_W'(PREAMBLE_BITS + 32);

  logic                busy_r;
  logic                busy_nxt;
  logic                is_write_r;
  logic                is_write_nxt;
  logic [POS_W-1:0]    pos_r;
  logic [POS_W-1:0]    pos_nxt;
  logic [HEADER_W-1:0] header_r;
  logic [HEADER_W-1:0] header_nxt;
  logic [DATA_W-1:0]   shift_r;
  logic [DATA_W-1:0]   shift_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  res_t                res_r;
  res_t                res;
  logic                pop;
  logic [POS_W-1:0]    last_pos;
  logic [POS_W-1:0]    hdr_off;
  logic [POS_W-1:0]    dat_off;
  logic [3:0]          hdr_idx;
  logic [3:0]          dat_idx;

  assign item_ready_o = !out_valid_r || out_tready;
  assign pop          = item_valid_i && item_ready_o;

  assign last_pos = is_write_r ? P_LAST_WR : P_LAST_RD;
  assign hdr_off  = pos_r - P_ADDR;
  assign dat_off  = pos_r - P_DATA;
  assign hdr_idx  = 4'(HEADER_W - 1) - hdr_off[3:0];
  assign dat_idx  = ~dat_off[3:0];

  // frame engine: one step per item
  always_comb begin
    busy_nxt     = busy_r;
    is_write_nxt = is_write_r;
    pos_nxt      = pos_r;
    header_nxt   = header_r;
    shift_nxt    = shift_r;
    res          = '0;
    unique case (item_i.cmd)
      CMD_START: begin
        if (busy_r) begin
          res.rejected = 1'b1;
        end else begin
          busy_nxt     = 1'b1;
          is_write_nxt = item_i.is_write;
          pos_nxt      = '0;
          header_nxt   = item_i.header;
          shift_nxt    = item_i.is_write ? item_i.wdata : '0;
        end
      end
      CMD_TICK: begin
        if (busy_r) begin
          // bit driven in this period
          if (pos_r < P_START0) begin
            res.mdio_drive_enable = 1'b1;
            res.mdio_out          = 1'b1;
          end else if (pos_r == P_START0) begin
            res.mdio_drive_enable = 1'b1;
          end else if (pos_r == P_START1) begin
            res.mdio_drive_enable = 1'b1;
            res.mdio_out          = 1'b1;
          end else if (pos_r == P_OP0) begin
            res.mdio_drive_enable = 1'b1;
            res.mdio_out          = !is_write_r;
          end else if (pos_r == P_OP1) begin
            res.mdio_drive_enable = 1'b1;
            res.mdio_out          = is_write_r;
          end else if (pos_r < P_TA0) begin
            res.mdio_drive_enable = 1'b1;
            res.mdio_out          = header_r[hdr_idx];
          end else if (is_write_r) begin
            if (pos_r == P_TA0) begin
              res.mdio_drive_enable = 1'b1;
              res.mdio_out          = 1'b1;
            end else if (pos_r == P_TA1) begin
              res.mdio_drive_enable = 1'b1;
            end else if (pos_r < P_LAST_WR) begin
              res.mdio_drive_enable = 1'b1;
              res.mdio_out          = shift_r[dat_idx];
            end
          end else if (pos_r >= P_TA1 && pos_r < P_LAST_RD) begin
            // read data comes in msb first
            shift_nxt = {shift_r[DATA_W-2:0], item_i.sample};
          end
          // frame end
          if (pos_r >= last_pos) begin
            res.done_res = 1'b1;
            if (!is_write_r) begin
              res.read_data = shift_r;
            end
            busy_nxt = 1'b0;
            pos_nxt  = '0;
          end else begin
            pos_nxt = pos_r + 1'b1;
          end
        end
      end
      default: ;
    endcase
    res.busy_res = busy_nxt;
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        busy_r <= busy_nxt;
        pos_r  <= pos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      is_write_r <= is_write_nxt;
      header_r   <= header_nxt;
      shift_r    <= shift_nxt;
      res_r      <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - DATA_W - 3)'(0), res_r.read_data, res_r.busy_res,
                       res_r.mdio_drive_enable, res_r.mdio_out};
  assign out_tlast  = res_r.done_res;
  assign out_tuser  = res_r.rejected;

`ifndef ASSERT_OFF
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> pos_r <= last_pos)
    else $error("bit position past frame end");

  a_idle_pos: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> pos_r == '0)
    else $error("bit position not cleared while idle");

  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    pop && item_i.cmd == CMD_TICK && busy_r && pos_r == last_pos
    |=> !busy_r && out_valid_r && res_r.done_res)
    else $error("frame did not end on its last bit");

  a_rdata_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.read_data != '0 |-> res_r.done_res && !res_r.busy_res)
    else $error("read data outside a finished frame");
`endif

endmodule

// File: src/mdio_clause22_master.sv
// Clause 22 MDIO management master driven one MDC period at a time. An item
// on tuser kind 0 or 1 starts a read or write frame with the PHY address,
// register address and write data from tdata; kind 2 is one MDC period, and
// its result tells what to drive on MDIO for that period (mdio_out, drive
// enable) while mdio_in in the same item is the level sampled at that
// period's rising MDC edge. A write frame takes PREAMBLE_BITS+33 periods, a
// read PREAMBLE_BITS+32; read data comes with tlast (done) on the last
// period, and a start while a frame runs is answered with tuser (rejected).
// Every item gives exactly one result. The block takes one item per clock
// while out_tready does not stall the output; an item passes the front
// classify stage, the two-entry queue and the frame engine with its output
// register, and the frame engine, taking one step per item, sets that rate.
module mdio_clause22_master
  import mdc22_pkg::*;
#(
  parameter int PREAMBLE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // phy_address[4:0], register_address[9:5], write_data[25:10], mdio_in[26]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // kind[1:0]
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // mdio_out[0], mdio_drive_enable[1], busy_res[2], read_data[18:3]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // done_res
  output logic                  out_tlast,
  // rejected
  output logic                  out_tuser
);

  item_t front_item;
  logic  front_valid;
  logic  front_ready;
  item_t q_item;
  logic  q_valid;
  logic  q_ready;

  // accept and classify
  mdc22_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .item_o       (front_item),
    .item_valid_o (front_valid),
    .item_ready_i (front_ready)
  );

  // decoupling queue
  mdc22_queue u_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_item_i  (front_item),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_item_o   (q_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready)
  );

  // frame engine
  mdc22_back #(
    .PREAMBLE_BITS (PREAMBLE_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_i       (q_item),
    .item_valid_i (q_valid),
    .item_ready_o (q_ready),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .out_tuser    (out_tuser)
  );

endmodule
